// File: hw/rtl/ucts_pkg.sv
`timescale 1ns / 1ps

package ucts_pkg;

    localparam int MAX_TDS = 16;
    localparam int CNT_W   = $clog2(MAX_TDS + 1);

    localparam logic [7:0]  TOKEN_SETUP = 8'h2D;
    localparam logic [7:0]  PID_IN      = 8'h69;
    localparam logic [7:0]  PID_OUT     = 8'hE1;
    localparam logic [10:0] LEN_NULL    = 11'h7FF;
    localparam logic [31:0] CW_BASE     = 32'h1880_0000;   // active, three retries
    localparam logic [31:0] CW_IOC      = 32'h0100_0000;
    localparam logic [31:0] ERR_MASK    = 32'h0076_0000;   // stall, buffer, babble, crc, bitstuff
    localparam logic [7:0]  PSIZE_DFLT  = 8'd8;
    localparam logic [14:0] SUM_MAX     = 15'h7FFF;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_STATUS  = 1'b1;

    localparam logic KIND_DESC    = 1'b0;
    localparam logic KIND_OUTCOME = 1'b1;

    localparam logic [1:0] STAGE_SETUP  = 2'd0;
    localparam logic [1:0] STAGE_DATA   = 2'd1;
    localparam logic [1:0] STAGE_STATUS = 2'd2;

    // classified work item handed from front to back
    typedef struct packed {
        logic        is_status;
        logic [6:0]  addr;
        logic [7:0]  psize;       // never zero
        logic [15:0] dlen;
        logic        din;
        logic        err;         // any error bit in the status word
        logic [11:0] act_len;     // actual length in bytes
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  stage;
        logic [31:0] token_word;
        logic [31:0] control_word;
        logic [15:0] buffer_offset;
        logic        last;
        logic        transfer_ok;
        logic [14:0] actual_total;
    } res_t;

    function automatic logic [31:0] make_token(input logic [7:0] pid, input logic [6:0] addr,
                                               input logic toggle, input logic [10:0] lf);
        make_token = {lf, 1'b0, toggle, 4'b0000, addr, pid};
    endfunction

endpackage

// File: hw/rtl/ucts_front.sv
`timescale 1ns / 1ps

module ucts_front
    import ucts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [6:0]  device_address,
    input  logic [7:0]  packet_size,
    input  logic [15:0] data_length,
    input  logic        data_in,
    input  logic [31:0] status_word,
    output logic        cmd_valid,
    output cmd_t        cmd_head,
    input  logic        cmd_pop
);

    cmd_t       entry;
    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;

    // classify the incoming item
    always_comb
    begin
        entry.is_status = (command == CMD_STATUS);
        entry.addr      = device_address;
        entry.psize     = (packet_size == 8'd0) ? PSIZE_DFLT : packet_size;
        entry.dlen      = data_length;
        entry.din       = data_in;
        entry.err       = |(status_word & ERR_MASK);
        entry.act_len   = (status_word[10:0] == LEN_NULL) ? 12'd0
                                                          : {1'b0, status_word[10:0]} + 12'd1;
    end

    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_head  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ cmd_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// File: hw/rtl/ucts_back.sv
`timescale 1ns / 1ps

module ucts_back
    import ucts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd_head,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DATA,
        ST_STAT
    } state_t;

    localparam logic [CNT_W-1:0] DATA_LIMIT = CNT_W'(MAX_TDS - 1);

    state_t           state_reg, state_next;
    logic [6:0]       addr_reg, addr_next;
    logic [7:0]       psize_reg, psize_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      off_reg, off_next;
    logic             toggle_reg, toggle_next;
    logic             din_reg, din_next;
    logic             has_data_reg, has_data_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [14:0]      sum_reg, sum_next;
    logic             err_reg, err_next;

    logic [15:0]      chunk;
    logic [15:0]      sum_add;
    logic [14:0]      sum_upd;
    logic             err_upd;
    logic [CNT_W-1:0] pos_inc;

    always_comb
    begin
        chunk   = (rem_reg < {8'd0, psize_reg}) ? rem_reg : {8'd0, psize_reg};
        err_upd = err_reg | cmd_head.err;
        pos_inc = pos_reg + CNT_W'(1);
        sum_add = {1'b0, sum_reg} + {4'd0, cmd_head.act_len};
        if (pos_reg != '0 && pos_inc < count_reg)
        begin
            sum_upd = sum_add[15] ? SUM_MAX : sum_add[14:0];
        end
        else
        begin
            sum_upd = sum_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        psize_next    = psize_reg;
        rem_next      = rem_reg;
        off_next      = off_reg;
        toggle_next   = toggle_reg;
        din_next      = din_reg;
        has_data_next = has_data_reg;
        n_next        = n_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        err_next      = err_reg;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        res           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop = 1'b1;
                    if (!cmd_head.is_status)
                    begin
                        addr_next     = cmd_head.addr;
                        psize_next    = cmd_head.psize;
                        rem_next      = cmd_head.dlen;
                        off_next      = 16'd0;
                        toggle_next   = 1'b1;
                        din_next      = cmd_head.din;
                        has_data_next = (cmd_head.dlen != 16'd0);
                        count_next    = '0;
                        pos_next      = '0;
                        sum_next      = 15'd0;
                        err_next      = 1'b0;
                        state_next    = ST_SETUP;
                    end
                    else if (count_reg != '0)
                    begin
                        err_next = err_upd;
                        sum_next = sum_upd;
                        pos_next = pos_inc;
                        if (pos_inc >= count_reg)
                        begin
                            res_push           = 1'b1;
                            res.kind           = KIND_OUTCOME;
                            res.transfer_ok    = !err_upd;
                            res.actual_total   = err_upd ? 15'd0 : sum_upd;
                            count_next         = '0;
                            pos_next           = '0;
                        end
                    end
                end
            end

            ST_SETUP:
            begin
                if (!res_full)
                begin
                    res_push         = 1'b1;
                    res.kind         = KIND_DESC;
                    res.stage        = STAGE_SETUP;
                    res.token_word   = make_token(TOKEN_SETUP, addr_reg, 1'b0, 11'd7);
                    res.control_word = CW_BASE;
                    n_next           = CNT_W'(1);
                    state_next       = (rem_reg != 16'd0 && CNT_W'(1) < DATA_LIMIT)
                                       ? ST_DATA : ST_STAT;
                end
            end

            ST_DATA:
            begin
                if (!res_full)
                begin
                    res_push          = 1'b1;
                    res.kind          = KIND_DESC;
                    res.stage         = STAGE_DATA;
                    res.token_word    = make_token(din_reg ? PID_IN : PID_OUT, addr_reg,
                                                   toggle_reg, 11'(chunk - 16'd1));
                    res.control_word  = CW_BASE;
                    res.buffer_offset = off_reg;
                    off_next          = off_reg + chunk;
                    rem_next          = rem_reg - chunk;
                    toggle_next       = !toggle_reg;
                    n_next            = n_reg + CNT_W'(1);
                    state_next        = (rem_next != 16'd0 && n_next < DATA_LIMIT)
                                        ? ST_DATA : ST_STAT;
                end
            end

            ST_STAT:
            begin
                if (!res_full)
                begin
                    res_push         = 1'b1;
                    res.kind         = KIND_DESC;
                    res.stage        = STAGE_STATUS;
                    res.token_word   = make_token((has_data_reg && din_reg) ? PID_OUT : PID_IN,
                                                  addr_reg, 1'b1, LEN_NULL);
                    res.control_word = CW_BASE | CW_IOC;
                    res.last         = 1'b1;
                    count_next       = n_reg + CNT_W'(1);
                    pos_next         = '0;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pos_reg      <= '0;
            sum_reg      <= 15'd0;
            err_reg      <= 1'b0;
            n_reg        <= '0;
            addr_reg     <= 7'd0;
            psize_reg    <= PSIZE_DFLT;
            rem_reg      <= 16'd0;
            off_reg      <= 16'd0;
            toggle_reg   <= 1'b0;
            din_reg      <= 1'b0;
            has_data_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            err_reg      <= err_next;
            n_reg        <= n_next;
            addr_reg     <= addr_next;
            psize_reg    <= psize_next;
            rem_reg      <= rem_next;
            off_reg      <= off_next;
            toggle_reg   <= toggle_next;
            din_reg      <= din_next;
            has_data_reg <= has_data_next;
        end
    end

endmodule

// File: hw/rtl/ucts_outq.sv
`timescale 1ns / 1ps

module ucts_outq
    import ucts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_push,
    input  res_t res_in,
    output logic res_full,
    input  logic pop,
    output logic empty,
    output res_t res_head
);

    res_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign do_pop   = pop && !empty;
    assign res_head = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ res_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, res_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

// File: hw/rtl/usb_control_td_sequencer.sv
`timescale 1ns / 1ps

// channel   | handshake                    | payload
// ----------+------------------------------+------------------------------------------
// request   | push / full, transfer when   | command, device_address, packet_size,
//           | push & !full                 | data_length, data_in, status_word
// result    | empty / pop, transfer when   | kind, stage, token_word, control_word,
//           | pop & !empty                 | buffer_offset, last, transfer_ok, actual_total
//
// a request item is loaded by the sequencer, then one descriptor per cycle is
// emitted while the result queue has room: setup, up to MAX_TDS - 2 data,
// status; a status word is folded in by the sequencer; items wait in a
// 2-entry queue, so the input side takes up to two items while the sequencer is busy
// results wait in a 2-entry queue; a full result queue stalls the sequencer only
// reset clears both queues and all chain state, no clearing pass is needed

module usb_control_td_sequencer
    import ucts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [6:0]  device_address,
    input  logic [7:0]  packet_size,
    input  logic [15:0] data_length,
    input  logic        data_in,
    input  logic [31:0] status_word,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [1:0]  stage,
    output logic [31:0] token_word,
    output logic [31:0] control_word,
    output logic [15:0] buffer_offset,
    output logic        last,
    output logic        transfer_ok,
    output logic [14:0] actual_total
);

    // front to back
    logic cmd_valid;
    cmd_t cmd_head;
    logic cmd_pop;

    // back to result queue
    logic res_full;
    logic res_push;
    res_t res;
    res_t res_head;

    // front: classifies each item (request or status word) and queues it
    ucts_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .command        (command),
        .device_address (device_address),
        .packet_size    (packet_size),
        .data_length    (data_length),
        .data_in        (data_in),
        .status_word    (status_word),
        .cmd_valid      (cmd_valid),
        .cmd_head       (cmd_head),
        .cmd_pop        (cmd_pop)
    );

    // back: walks the descriptor chain and folds in completion status
    ucts_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // result queue decouples the sequencer from the consumer
    ucts_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .res_head (res_head)
    );

    assign kind          = res_head.kind;
    assign stage         = res_head.stage;
    assign token_word    = res_head.token_word;
    assign control_word  = res_head.control_word;
    assign buffer_offset = res_head.buffer_offset;
    assign last          = res_head.last;
    assign transfer_ok   = res_head.transfer_ok;
    assign actual_total  = res_head.actual_total;

`ifndef SYNTHESIS
    // sequencer never writes into a full result queue
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written while queue full");

    // sequencer only takes work the front has queued
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from empty queue");

    // a failed transfer reports no byte count
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind == KIND_OUTCOME) |-> (res.transfer_ok || res.actual_total == 15'd0))
        else $error("failed transfer carries a byte count");
`endif

endmodule

// File: tb/sv/tb_usb_control_td_sequencer.sv
`timescale 1ns / 1ps

module tb_usb_control_td_sequencer;
    import ucts_pkg::*;

    // token and control word fields, kept apart from the design's package
    localparam logic [7:0]  TOK_SETUP   = 8'h2D;
    localparam logic [7:0]  TOK_IN      = 8'h69;
    localparam logic [7:0]  TOK_OUT     = 8'hE1;
    localparam logic [10:0] LEN_NONE    = 11'h7FF;
    localparam logic [31:0] TD_ACTIVE   = 32'h0080_0000;
    localparam logic [31:0] TD_RETRIES  = 32'h1800_0000;
    localparam logic [31:0] TD_IOC      = 32'h0100_0000;
    localparam logic [31:0] TD_ERRORS   = 32'h0076_0000;
    localparam int          SUM_CEILING = 32767;
    localparam int          ERR_BIT_POS [5] = '{17, 18, 20, 21, 22};

    localparam int RANDOM_ITEMS = 180;
    localparam int MAX_GAP      = 18;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = MAX_TDS + 8;

    // expected descriptor chains and outcomes, plus the chain bookkeeping
    class td_chain_checker;
        res_t        expected_tds[$];
        int unsigned chain_len;
        int unsigned status_idx;
        int unsigned len_sum;
        bit          err_flag;
        int          errors;
        int          checked;

        function new();
            chain_len  = 0;
            status_idx = 0;
            len_sum    = 0;
            err_flag   = 0;
            errors     = 0;
            checked    = 0;
        endfunction

        function logic [31:0] pack_token(logic [7:0] pid, logic [6:0] addr, logic toggle,
                                         int unsigned nbytes);
            logic [31:0] lf;
            lf = (nbytes == 0) ? {21'd0, LEN_NONE} : ((nbytes - 1) & 32'h7FF);
            return {24'd0, pid} | ({25'd0, addr} << 8) | ({31'd0, toggle} << 19) | (lf << 21);
        endfunction

        function void build_chain(logic [6:0] addr, logic [7:0] psize, logic [15:0] dlen,
                                  logic din);
            int unsigned left;
            int unsigned chunk;
            int unsigned offset;
            int unsigned mps;
            logic        toggle;
            logic [7:0]  stage_pid;
            logic [7:0]  ack_pid;
            res_t        td;
            mps       = (psize == 0) ? 8 : psize;
            left      = dlen;
            offset    = 0;
            toggle    = 1'b1;
            stage_pid = din ? TOK_IN : TOK_OUT;
            ack_pid   = (dlen != 0 && din) ? TOK_OUT : TOK_IN;

            td = '0;
            td.kind         = KIND_DESC;
            td.stage        = STAGE_SETUP;
            td.token_word   = pack_token(TOK_SETUP, addr, 1'b0, 8);
            td.control_word = TD_ACTIVE | TD_RETRIES;
            expected_tds.push_back(td);
            chain_len = 1;

            // data stage, capped at MAX_TDS-2 descriptors, the rest is dropped
            while (left > 0 && chain_len < MAX_TDS - 1) begin
                chunk = (left < mps) ? left : mps;
                td = '0;
                td.kind          = KIND_DESC;
                td.stage         = STAGE_DATA;
                td.token_word    = pack_token(stage_pid, addr, toggle, chunk);
                td.control_word  = TD_ACTIVE | TD_RETRIES;
                td.buffer_offset = offset[15:0];
                expected_tds.push_back(td);
                offset    = offset + chunk;
                left      = left - chunk;
                toggle    = ~toggle;
                chain_len = chain_len + 1;
            end

            td = '0;
            td.kind         = KIND_DESC;
            td.stage        = STAGE_STATUS;
            td.token_word   = pack_token(ack_pid, addr, 1'b1, 0);
            td.control_word = TD_ACTIVE | TD_RETRIES | TD_IOC;
            td.last         = 1'b1;
            expected_tds.push_back(td);
            chain_len  = chain_len + 1;
            status_idx = 0;
            len_sum    = 0;
            err_flag   = 0;
        endfunction

        // returns 0 when the word is dropped for lack of a pending chain
        function bit absorb_status(logic [31:0] sw);
            int unsigned raw_len;
            res_t        outcome;
            if (chain_len == 0 || status_idx >= chain_len)
                return 0;
            if ((sw & TD_ERRORS) != 0)
                err_flag = 1;
            if (status_idx >= 1 && status_idx + 1 < chain_len) begin
                raw_len = sw[10:0];
                len_sum = len_sum + ((raw_len == LEN_NONE) ? 0 : raw_len + 1);
                if (len_sum > SUM_CEILING)
                    len_sum = SUM_CEILING;
            end
            status_idx = status_idx + 1;
            if (status_idx >= chain_len) begin
                outcome = '0;
                outcome.kind         = KIND_OUTCOME;
                outcome.transfer_ok  = !err_flag;
                outcome.actual_total = err_flag ? 15'd0 : len_sum[14:0];
                expected_tds.push_back(outcome);
                chain_len  = 0;
                status_idx = 0;
            end
            return 1;
        endfunction

        function bit note_item(logic cmd, logic [6:0] addr, logic [7:0] psize,
                               logic [15:0] dlen, logic din, logic [31:0] sw);
            if (cmd == CMD_REQUEST) begin
                build_chain(addr, psize, dlen, din);
                return 1;
            end
            return absorb_status(sw);
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            checked++;
            if (expected_tds.size() == 0) begin
                $error("result with nothing expected: 0x%0h", got);
                errors++;
                return;
            end
            want = expected_tds.pop_front();
            cmp("kind",          want.kind,          got.kind);
            cmp("stage",         want.stage,         got.stage);
            cmp("token_word",    want.token_word,    got.token_word);
            cmp("control_word",  want.control_word,  got.control_word);
            cmp("buffer_offset", want.buffer_offset, got.buffer_offset);
            cmp("last",          want.last,          got.last);
            cmp("transfer_ok",   want.transfer_ok,   got.transfer_ok);
            cmp("actual_total",  want.actual_total,  got.actual_total);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        command;
    logic [6:0]  device_address;
    logic [7:0]  packet_size;
    logic [15:0] data_length;
    logic        data_in;
    logic [31:0] status_word;
    logic        empty;
    logic        pop;
    logic        kind;
    logic [1:0]  stage;
    logic [31:0] token_word;
    logic [31:0] control_word;
    logic [15:0] buffer_offset;
    logic        last;
    logic        transfer_ok;
    logic [14:0] actual_total;

    td_chain_checker board;
    bit              calm_in;
    int              effective_items;
    int              n_requests;
    int              n_status;

    usb_control_td_sequencer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .command        (command),
        .device_address (device_address),
        .packet_size    (packet_size),
        .data_length    (data_length),
        .data_in        (data_in),
        .status_word    (status_word),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .stage          (stage),
        .token_word     (token_word),
        .control_word   (control_word),
        .buffer_offset  (buffer_offset),
        .last           (last),
        .transfer_ok    (transfer_ok),
        .actual_total   (actual_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one input transfer: optional idle gap, then hold push until full drops;
    // push stays high on exit so back-to-back items need no gap
    task automatic send_item(input logic cmd, input logic [6:0] addr, input logic [7:0] psize,
                             input logic [15:0] dlen, input logic din, input logic [31:0] sw);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        command        = cmd;
        device_address = addr;
        packet_size    = psize;
        data_length    = dlen;
        data_in        = din;
        status_word    = sw;
        push           = 1'b1;
        do @(posedge clk); while (full);
        if (board.note_item(cmd, addr, psize, dlen, din, sw))
            effective_items++;
        if (cmd == CMD_REQUEST)
            n_requests++;
        else
            n_status++;
        @(negedge clk);
    endtask

    // status word for one descriptor, clean or carrying an error bit
    function automatic logic [31:0] status_for(bit faulty);
        logic [31:0] w;
        w = $urandom;
        if (faulty)
        begin
            if ((w & TD_ERRORS) == 0)
                w = w | (32'h1 << ERR_BIT_POS[$urandom_range(0, 4)]);
        end
        else
            w = w & ~TD_ERRORS;
        // occasionally the null length code, counted as zero bytes
        if ($urandom_range(0, 7) == 0)
            w[10:0] = LEN_NONE;
        return w;
    endfunction

    // result side: random pop gaps with calm stretches of back-to-back pops
    initial
    begin : result_sink
        int   gap;
        bit   calm_out;
        res_t got;
        pop      = 1'b0;
        calm_out = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                calm_out = !calm_out;
            gap = calm_out ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                pop = 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop = 1'b1;
            do @(posedge clk); while (empty);
            got.kind          = kind;
            got.stage         = stage;
            got.token_word    = token_word;
            got.control_word  = control_word;
            got.buffer_offset = buffer_offset;
            got.last          = last;
            got.transfer_ok   = transfer_ok;
            got.actual_total  = actual_total;
            board.check_result(got);
            @(negedge clk);
        end
    end

    // watchdog: ends the run when neither side moves for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("[usb_control_td_sequencer] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int          k;
        int          tds;
        int          feed;
        int          bad_at;
        int          roll;
        logic [7:0]  ps;
        logic [15:0] dl;
        logic [31:0] sw;

        board           = new();
        calm_in         = 1'b0;
        effective_items = 0;
        n_requests      = 0;
        n_status        = 0;
        rst_n           = 1'b0;
        push            = 1'b0;
        command         = CMD_REQUEST;
        device_address  = '0;
        packet_size     = '0;
        data_length     = '0;
        data_in         = 1'b0;
        status_word     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        // status word with no chain pending, dropped
        send_item(CMD_STATUS, 7'd0, 8'd0, 16'd0, 1'b0, 32'hFFFF_FFFF);
        // top address, packet size 0 taken as 8, IN data stage of 20 bytes
        send_item(CMD_REQUEST, 7'd127, 8'd0, 16'd20, 1'b1, 32'd0);
        // active bit left set, null length code, then plain lengths
        send_item(CMD_STATUS, 7'd0, 8'd0, 16'd0, 1'b0, 32'h0080_0007);
        send_item(CMD_STATUS, 7'd0, 8'd0, 16'd0, 1'b0, {21'd0, LEN_NONE});
        send_item(CMD_STATUS, 7'd0, 8'd0, 16'd0, 1'b0, 32'h0000_0007);
        send_item(CMD_STATUS, 7'd0, 8'd0, 16'd0, 1'b0, 32'h0000_0003);
        send_item(CMD_STATUS, 7'd0, 8'd0, 16'd0, 1'b0, 32'h0000_0000);
        // no data stage, largest packet size, then abandoned by a new request
        send_item(CMD_REQUEST, 7'd0, 8'd255, 16'd0, 1'b0, 32'd0);
        // longest data stage in 1-byte packets: excess data dropped
        send_item(CMD_REQUEST, 7'h55, 8'd1, 16'hFFFF, 1'b0, 32'd0);
        tds = board.chain_len;
        for (k = 0; k < tds; k++)
        begin
            // each error bit once across the first words
            sw = 32'h0000_07FE;
            if (k < 5)
                sw = sw | (32'h1 << ERR_BIT_POS[k]);
            send_item(CMD_STATUS, 7'd0, 8'd0, 16'd0, 1'b0, sw);
        end
        // one more word after the outcome, dropped
        send_item(CMD_STATUS, 7'd0, 8'd0, 16'd0, 1'b0, 32'h0000_0001);

        // --- random part: mostly complete transfers with random content ---
        effective_items = 0;
        while (effective_items < RANDOM_ITEMS)
        begin
            calm_in = ($urandom_range(0, 4) == 0);
            roll    = $urandom_range(0, 99);
            if (roll < 6)
            begin
                // stray status word
                send_item(CMD_STATUS, 7'($urandom), 8'($urandom), 16'($urandom),
                          1'($urandom), $urandom);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       ps = 8'd0;
                    1:       ps = 8'($urandom_range(1, 16));
                    default: ps = 8'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0:       dl = 16'd0;
                    1:       dl = 16'($urandom_range(1, 64));
                    2:       dl = 16'($urandom_range(1, 600));
                    default: dl = 16'($urandom);
                endcase
                send_item(CMD_REQUEST, 7'($urandom), ps, dl, 1'($urandom), $urandom);
                tds = board.chain_len;
                // broken sequence: chain cut short, the next request abandons it
                feed   = (roll < 16) ? $urandom_range(0, tds - 1) : tds;
                bad_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, tds - 1) : tds;
                for (k = 0; k < feed; k++)
                    send_item(CMD_STATUS, 7'($urandom), 8'($urandom), 16'($urandom),
                              1'($urandom), status_for(k == bad_at));
            end
        end

        // --- drain ---
        push = 1'b0;
        @(negedge clk);
        while (board.expected_tds.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.expected_tds.size() > 0)
        begin
            $error("%0d expected results never arrived", board.expected_tds.size());
            board.errors++;
        end

        $display("sent %0d requests and %0d status words, incl. stray and abandoned chains",
                 n_requests, n_status);
        $display("checked %0d descriptors and outcomes field by field", board.checked);
        if (board.errors == 0)
            $display("[usb_control_td_sequencer] OK");
        else
            $display("[usb_control_td_sequencer] ERROR");
        $finish;
    end

endmodule
